// File: rtl/core/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared constants and codes of the sorted table binary search block.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 32;

  // Entry index, table length (holds TABLE_DEPTH itself), signed position.
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int LEN_W = IDX_W + 1;
  localparam int POS_W = LEN_W + 1;

  // Opcode of a request item.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

endpackage

// File: rtl/core/sbs_ifs.sv
// ----------------------------------------------------------------------------
// sbs_ifs
// Valid/ready channels of the sorted table binary search block.
// ----------------------------------------------------------------------------
interface sbs_req_if;
  import sbs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [IDX_W-1:0]         entry_index;
  logic signed [KEY_WIDTH-1:0] key;
  modport source (output valid, opcode, entry_index, key, input ready);
  modport sink   (input valid, opcode, entry_index, key, output ready);
endinterface

interface sbs_rsp_if;
  import sbs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [POS_W-1:0] position;
  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

interface sbs_cfg_if;
  import sbs_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] table_length;
  modport source (output valid, table_length, input ready);
  modport sink   (input valid, table_length, output ready);
endinterface

// File: rtl/core/sorted_table_binary_search_top.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Binary search over an ascending table of signed keys held in one RAM.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload                        | transfer
//  --------+-----------+--------------------------------+----------------------
//  cfg     | in        | table_length                   | valid & ready
//  req     | in        | opcode, entry_index, key       | valid & ready
//  rsp     | out       | found, position                | valid & ready
//
//  A write request gives no response. A search is accepted in ST_IDLE,
//  then runs a RAM read (ST_PROBE) and a compare (ST_CMP) per probe, up to
//  log2(depth)+1 = 11 probes, and is handed off from ST_HOLD. The probe
//  loop runs through the one RAM read port.
//  Reset clears table_length and the control state; the key table is
//  not cleared and must be written before it is searched.
//  A finished result waits in the response register; a stalled rsp side
//  holds the search engine only when a second result is ready to go.
//
module sorted_table_binary_search_top (
  input  logic      clk,
  input  logic      rst,
  sbs_cfg_if.sink   cfg,
  sbs_req_if.sink   req,
  sbs_rsp_if.source rsp
);
  import sbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_HOLD
  } state_t;

  state_t                      state;
  logic [LEN_W-1:0]            table_length;
  logic signed [KEY_WIDTH-1:0] needle;
  logic signed [POS_W-1:0]     low;
  logic signed [POS_W-1:0]     high;
  logic [IDX_W-1:0]            mid;
  logic                        res_found;
  logic signed [POS_W-1:0]     res_pos;

  logic                        req_fire;
  logic                        ram_we;
  logic [IDX_W-1:0]            probe_addr;
  logic [KEY_WIDTH-1:0]        probe_data;
  logic signed [POS_W-1:0]     mid_sum;
  logic [LEN_W-1:0]            len_sat;
  logic signed [POS_W-1:0]     low_next;
  logic signed [POS_W-1:0]     high_next;
  logic                        probe_gt;
  logic                        probe_lt;

  // Configuration is taken at any time; the register is only read on accept.
  assign cfg.ready = 1'b1;

  // Accept one request at a time, only while the engine is idle.
  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign ram_we    = req_fire && (req.opcode == OP_WRITE);

  // Saturate the searched length to the table depth.
  assign len_sat = (table_length > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : table_length;

  // Midpoint of a live range: low and high are both non-negative here.
  assign mid_sum    = low + high;
  assign probe_addr = mid_sum[IDX_W:1];

  sbs_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(TABLE_DEPTH)
  ) u_keys (
    .clk  (clk),
    .we   (ram_we),
    .waddr(req.entry_index),
    .wdata(req.key),
    .raddr(probe_addr),
    .rdata(probe_data)
  );

  // Compare the entry read back at mid with the needle and narrow the range.
  assign probe_gt = $signed(probe_data) > needle;
  assign probe_lt = $signed(probe_data) < needle;

  always_comb begin
    low_next  = low;
    high_next = high;
    if (probe_gt) begin
      high_next = $signed(POS_W'(mid)) - POS_W'(1);
    end else if (probe_lt) begin
      low_next = $signed(POS_W'(mid)) + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      table_length <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        table_length <= cfg.table_length;
      end

      // Drop the response once it has been transferred, unless the next
      // one is handed over at this same edge.
      if (rsp.valid && rsp.ready && (state != ST_HOLD)) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req_fire && (req.opcode == OP_SEARCH)) begin
            needle <= req.key;
            low    <= '0;
            high   <= $signed(POS_W'(len_sat)) - POS_W'(1);
            if (len_sat == '0) begin
              // Empty table: not found, insertion point zero.
              res_found <= 1'b0;
              res_pos   <= -POS_W'(1);
              state     <= ST_HOLD;
            end else begin
              state <= ST_PROBE;
            end
          end
        end

        ST_PROBE: begin
          // RAM read of the midpoint is issued this cycle.
          mid   <= probe_addr;
          state <= ST_CMP;
        end

        ST_CMP: begin
          low  <= low_next;
          high <= high_next;
          if (!probe_gt && !probe_lt) begin
            res_found <= 1'b1;
            res_pos   <= $signed(POS_W'(mid)) + POS_W'(1);
            state     <= ST_HOLD;
          end else if (low_next > high_next) begin
            res_found <= 1'b0;
            res_pos   <= -(low_next + POS_W'(1));
            state     <= ST_HOLD;
          end else begin
            state <= ST_PROBE;
          end
        end

        ST_HOLD: begin
          // Hand the result over once the response register is free.
          if (!rsp.valid || rsp.ready) begin
            rsp.valid    <= 1'b1;
            rsp.found    <= res_found;
            rsp.position <= res_pos;
            state        <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A compare always follows the read issued in the cycle before.
  a_cmp_after_probe: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> ($past(state) == ST_PROBE))
    else $error("compare without a preceding RAM read");

  // A probe is only issued over a non-empty, non-negative range.
  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> ((low <= high) && (low >= 0)))
    else $error("probe issued over an empty range");

  // A hit reports a positive position, a miss a negative one.
  a_pos_sign: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.found ? (rsp.position > 0) : (rsp.position < 0)))
    else $error("response position sign does not match found");

  // The table is only written while no search is under way.
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == ST_IDLE) && !$past(state == ST_HOLD) || (state == ST_IDLE)))
    else $error("table write during a search");

endmodule

// File: rtl/core/sbs_ram.sv
// ----------------------------------------------------------------------------
// sbs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
